[hdl/sst_pkg.sv]
package sst_pkg;

  localparam int TABLE_ENTRIES = 12;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SLOT_W = 4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  localparam logic [1:0] ACT_NEW        = 2'd0;
  localparam logic [1:0] ACT_UPDATED    = 2'd1;
  localparam logic [1:0] ACT_NOT_PLACED = 2'd2;
  localparam logic [1:0] ACT_READ       = 2'd3;

  localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(TABLE_ENTRIES);

  typedef struct packed {
    logic       req_type;
    logic [7:0] sat_number;
    logic [6:0] elevation_deg;
    logic [8:0] azimuth_deg;
    logic [6:0] signal_noise;
    logic [7:0] visible_total;
    logic [3:0] read_index;
  } in_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] slot;
    logic [7:0] out_sat_number;
    logic [6:0] out_elevation;
    logic [8:0] out_azimuth;
    logic [6:0] out_signal_noise;
    logic [7:0] visible_count;
  } out_t;

  // one table entry
  typedef struct packed {
    logic [7:0] num;
    logic [6:0] elev;
    logic [8:0] azim;
    logic [6:0] snr;
  } rec_t;

  // handed from one cell to the next
  typedef struct packed {
    rec_t rec;
    logic ge;
    logic nz;
    logic fwd;
  } link_t;

  // per-cell status seen by the top level
  typedef struct packed {
    logic first;
    logic gt;
  } stat_t;

endpackage

[hdl/sst_cell.sv]
module sst_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ins_en,
  input  logic          shift_en,
  input  sst_pkg::rec_t  carry,
  input  sst_pkg::link_t prev,
  output sst_pkg::link_t next,
  output sst_pkg::stat_t stat,
  output sst_pkg::rec_t  entry
);

  sst_pkg::rec_t ent_r;
  sst_pkg::rec_t ent_nxt;
  logic ge;
  logic gt;
  logic first;

  // table stays sorted, so ge is monotone along the row
  assign ge    = carry.num >= ent_r.num;
  assign gt    = carry.num > ent_r.num;
  assign first = ge && !prev.ge;

  assign next.rec = ent_r;
  assign next.ge  = ge;
  assign next.nz  = ent_r.num != 8'd0;
  // shift keeps going past this cell unless two empty slots meet
  assign next.fwd = first || (ge && prev.nz);

  assign stat.first = first;
  assign stat.gt    = gt;
  assign entry      = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ins_en) begin
      if (first) begin
        ent_nxt = carry;
      end else if (shift_en && prev.fwd) begin
        ent_nxt = prev.rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

[hdl/sorted_satellite_table_insert_top.sv]
// the result of an accepted input beat is held in an output register and shown in the cycle after it
// throughput: one beat per cycle while the result side is not stalled
// all cells compare the carried number in the same cycle, and every cell that changes writes its entry in that cycle
// reset (rst_n low, synchronous) clears every table entry, the visible count and out_valid
module sorted_satellite_table_insert_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sst_pkg::out_t out_data
);

  logic          accept;
  logic          ins_en;
  logic          shift_en;
  sst_pkg::rec_t carry;
  sst_pkg::rec_t entries [sst_pkg::TABLE_ENTRIES];
  sst_pkg::link_t links  [sst_pkg::TABLE_ENTRIES];
  sst_pkg::stat_t stats  [sst_pkg::TABLE_ENTRIES];
  logic [sst_pkg::TABLE_ENTRIES-1:0] first_vec;
  logic [sst_pkg::TABLE_ENTRIES-1:0] hit_gt;

  logic [sst_pkg::SLOT_W-1:0] ins_slot;
  logic [sst_pkg::IDX_W-1:0]  rd_idx;
  logic                       rd_in_range;
  sst_pkg::rec_t              rd_rec;
  sst_pkg::out_t              res;

  logic          out_valid_r, out_valid_nxt;
  sst_pkg::out_t out_data_r;
  logic [7:0]    vis_r, vis_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign ins_en   = accept && (in_data.req_type == sst_pkg::REQ_INSERT);

  assign carry.num  = in_data.sat_number;
  assign carry.elev = in_data.elevation_deg;
  assign carry.azim = in_data.azimuth_deg;
  assign carry.snr  = in_data.signal_noise;

  for (genvar k = 0; k < sst_pkg::TABLE_ENTRIES; k++) begin : g_cell
    sst_pkg::link_t prev;
    if (k == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = links[k-1];
    end
    sst_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ins_en   (ins_en),
      .shift_en (shift_en),
      .carry    (carry),
      .prev     (prev),
      .next     (links[k]),
      .stat     (stats[k]),
      .entry    (entries[k])
    );
    assign first_vec[k] = stats[k].first;
    assign hit_gt[k]    = stats[k].first && stats[k].gt;
  end

  // a strictly larger number at the insert point pushes the lower entries down
  assign shift_en = |hit_gt;

  always_comb begin
    ins_slot = '0;
    for (int k = 0; k < sst_pkg::TABLE_ENTRIES; k++) begin
      if (first_vec[k]) begin
        ins_slot = ins_slot | sst_pkg::SLOT_W'(k);
      end
    end
  end

  assign rd_idx      = sst_pkg::IDX_W'(in_data.read_index);
  assign rd_in_range = 32'(in_data.read_index) < sst_pkg::TABLE_ENTRIES;

  always_comb begin
    rd_rec = '0;
    for (int k = 0; k < sst_pkg::TABLE_ENTRIES; k++) begin
      if (rd_in_range && rd_idx == sst_pkg::IDX_W'(k)) begin
        rd_rec = entries[k];
      end
    end
  end

  always_comb begin
    res     = '0;
    vis_nxt = vis_r;
    if (in_data.req_type == sst_pkg::REQ_INSERT) begin
      vis_nxt = in_data.visible_total;
      if (first_vec == '0) begin
        res.action = sst_pkg::ACT_NOT_PLACED;
        res.slot   = sst_pkg::SLOT_NONE;
      end else if (shift_en) begin
        res.action = sst_pkg::ACT_NEW;
        res.slot   = ins_slot;
      end else begin
        res.action = sst_pkg::ACT_UPDATED;
        res.slot   = ins_slot;
      end
    end else begin
      res.action           = sst_pkg::ACT_READ;
      res.slot             = in_data.read_index;
      res.out_sat_number   = rd_rec.num;
      res.out_elevation    = rd_rec.elev;
      res.out_azimuth      = rd_rec.azim;
      res.out_signal_noise = rd_rec.snr;
    end
    res.visible_count = vis_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      vis_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        vis_r <= vis_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // table order keeps at most one insert point
  a_single_insert_point: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_vec))
    else $error("more than one insert point in table");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_insert_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.action != sst_pkg::ACT_READ) |->
      (out_data.out_sat_number == 8'd0 && out_data.out_azimuth == 9'd0))
    else $error("insert result carries entry data");

  a_not_placed_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.action == sst_pkg::ACT_NOT_PLACED) |->
      (out_data.slot == sst_pkg::SLOT_NONE))
    else $error("not placed result with wrong slot");

endmodule

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_PER_PHASE = 350;
  localparam int RANDOM_TOTAL = 4 * RANDOM_PER_PHASE;

  typedef struct packed {
    logic [7:0] num;
    logic [6:0] elev;
    logic [8:0] azim;
    logic [6:0] snr;
  } entry_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sst_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sst_pkg::out_t out_data;

  // predictor state
  entry_t sat_tab [sst_pkg::TABLE_ENTRIES];
  logic [7:0] seen_count;

  sst_pkg::in_t req_queue[$];
  sst_pkg::out_t results_due[$];

  int idle_pct = 0;
  int stall_pct = 0;
  logic holdoff = 1'b0;
  int accepted_beats = 0;
  int result_beats = 0;
  int mismatches = 0;
  int gen_count = 0;
  int cycles = 0;

  int idle_by_phase[4] = '{0, 50, 0, 19};
  int stall_by_phase[4] = '{0, 0, 50, 19};

  sorted_satellite_table_insert_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < sst_pkg::TABLE_ENTRIES; i++) sat_tab[i] = '0;
    seen_count = '0;
  end

  // applies one request to the predicted table, returns the expected result
  function automatic sst_pkg::out_t table_apply(sst_pkg::in_t req);
    sst_pkg::out_t r;
    entry_t carry;
    entry_t prev;
    bit placed;
    bit done;
    int i;
    r = '0;
    if (req.req_type == sst_pkg::REQ_INSERT) begin
      carry.num = req.sat_number;
      carry.elev = req.elevation_deg;
      carry.azim = req.azimuth_deg;
      carry.snr = req.signal_noise;
      seen_count = req.visible_total;
      r.action = sst_pkg::ACT_NOT_PLACED;
      r.slot = sst_pkg::SLOT_NONE;
      placed = 1'b0;
      done = 1'b0;
      for (i = 0; i < sst_pkg::TABLE_ENTRIES && !done; i++) begin
        if (carry.num > sat_tab[i].num) begin
          // carried record takes the slot, old one moves on down
          prev = sat_tab[i];
          sat_tab[i] = carry;
          carry = prev;
          if (!placed) begin
            placed = 1'b1;
            r.action = sst_pkg::ACT_NEW;
            r.slot = sst_pkg::SLOT_W'(i);
          end
        end else if (carry.num == sat_tab[i].num) begin
          sat_tab[i] = carry;
          if (!placed) begin
            r.action = sst_pkg::ACT_UPDATED;
            r.slot = sst_pkg::SLOT_W'(i);
          end
          done = 1'b1;
        end
      end
    end else begin
      r.action = sst_pkg::ACT_READ;
      r.slot = req.read_index;
      if (req.read_index < sst_pkg::TABLE_ENTRIES) begin
        r.out_sat_number = sat_tab[req.read_index].num;
        r.out_elevation = sat_tab[req.read_index].elev;
        r.out_azimuth = sat_tab[req.read_index].azim;
        r.out_signal_noise = sat_tab[req.read_index].snr;
      end
    end
    r.visible_count = seen_count;
    return r;
  endfunction

  function automatic sst_pkg::in_t mk_insert(logic [7:0] num, logic [6:0] elev,
                                             logic [8:0] azim, logic [6:0] snr,
                                             logic [7:0] vis);
    sst_pkg::in_t req;
    req.req_type = sst_pkg::REQ_INSERT;
    req.sat_number = num;
    req.elevation_deg = elev;
    req.azimuth_deg = azim;
    req.signal_noise = snr;
    req.visible_total = vis;
    req.read_index = 4'(num);
    return req;
  endfunction

  function automatic sst_pkg::in_t mk_read(logic [3:0] idx);
    sst_pkg::in_t req;
    req = '0;
    req.req_type = sst_pkg::REQ_READ;
    req.read_index = idx;
    return req;
  endfunction

  // numbers mostly come from a band that climbs over the run so that new
  // entries keep shifting the table while updates stay common
  task automatic queue_random(input int count);
    sst_pkg::in_t req;
    int lo;
    int pick;
    for (int k = 0; k < count; k++) begin
      lo = (gen_count * 225) / RANDOM_TOTAL;
      if (lo > 225) lo = 225;
      pick = $urandom_range(99);
      if (pick < 75) req.sat_number = 8'($urandom_range(lo + 30, lo));
      else if (pick < 96) req.sat_number = 8'($urandom_range(255));
      else req.sat_number = 8'd0;
      req.elevation_deg = ($urandom_range(9) != 0) ? 7'($urandom_range(90)) :
                                                     7'($urandom_range(127));
      req.azimuth_deg = ($urandom_range(9) != 0) ? 9'($urandom_range(359)) :
                                                   9'($urandom_range(511));
      req.signal_noise = ($urandom_range(9) != 0) ? 7'($urandom_range(99)) :
                                                    7'($urandom_range(127));
      req.visible_total = 8'($urandom_range(255));
      req.read_index = ($urandom_range(9) != 0) ?
                       4'($urandom_range(sst_pkg::TABLE_ENTRIES - 1)) :
                       4'($urandom_range(15, sst_pkg::TABLE_ENTRIES));
      req.req_type = ($urandom_range(99) < 30) ? sst_pkg::REQ_READ : sst_pkg::REQ_INSERT;
      req_queue.push_back(req);
      gen_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        results_due.push_back(table_apply(in_data));
        accepted_beats++;
      end
      if (!in_valid || !in_stall) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data <= req_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side stall
  always @(posedge clk) begin
    sst_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        result_beats++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat %0d: act=%0d slot=%0d", result_beats,
                     out_data.action, out_data.slot);
        end else begin
          want = results_due.pop_front();
          if (out_data.action !== want.action || out_data.slot !== want.slot ||
              out_data.out_sat_number !== want.out_sat_number ||
              out_data.out_elevation !== want.out_elevation ||
              out_data.out_azimuth !== want.out_azimuth ||
              out_data.out_signal_noise !== want.out_signal_noise ||
              out_data.visible_count !== want.visible_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at result beat %0d", result_beats);
              $display("  exp act=%0d slot=%0d num=%0d el=%0d az=%0d snr=%0d vis=%0d",
                       want.action, want.slot, want.out_sat_number, want.out_elevation,
                       want.out_azimuth, want.out_signal_noise, want.visible_count);
              $display("  got act=%0d slot=%0d num=%0d el=%0d az=%0d snr=%0d vis=%0d",
                       out_data.action, out_data.slot, out_data.out_sat_number,
                       out_data.out_elevation, out_data.out_azimuth,
                       out_data.out_signal_noise, out_data.visible_count);
            end
          end
        end
      end
      out_stall <= holdoff || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // long result-side hold-off while the sender keeps offering beats
  initial begin
    while (accepted_beats < 300) @(negedge clk);
    holdoff = 1'b1;
    repeat (80) @(negedge clk);
    holdoff = 1'b0;
  end

  initial begin
    // empty table: reads, out-of-range read, zero insert fills the first empty slot
    req_queue.push_back(mk_read(4'd0));
    req_queue.push_back(mk_read(4'd11));
    req_queue.push_back(mk_read(4'd15));
    req_queue.push_back(mk_insert(8'd0, 7'd90, 9'd359, 7'd99, 8'd255));
    // new entry on top, the zero record shifts into the empty slot below
    req_queue.push_back(mk_insert(8'd100, 7'd0, 9'd0, 7'd0, 8'd0));
    req_queue.push_back(mk_insert(8'd255, 7'd127, 9'd511, 7'd127, 8'd12));
    req_queue.push_back(mk_insert(8'd100, 7'd45, 9'd180, 7'd50, 8'd7));
    req_queue.push_back(mk_insert(8'd50, 7'd1, 9'd256, 7'd64, 8'd128));
    req_queue.push_back(mk_insert(8'd1, 7'd64, 9'd1, 7'd1, 8'd1));
    req_queue.push_back(mk_read(4'd1));
    req_queue.push_back(mk_insert(8'd200, 7'd10, 9'd20, 7'd30, 8'd40));
    req_queue.push_back(mk_insert(8'd180, 7'd11, 9'd21, 7'd31, 8'd41));
    req_queue.push_back(mk_insert(8'd160, 7'd12, 9'd22, 7'd32, 8'd42));
    req_queue.push_back(mk_insert(8'd140, 7'd13, 9'd23, 7'd33, 8'd43));
    req_queue.push_back(mk_insert(8'd120, 7'd14, 9'd24, 7'd34, 8'd44));
    req_queue.push_back(mk_insert(8'd90, 7'd15, 9'd25, 7'd35, 8'd45));
    req_queue.push_back(mk_insert(8'd80, 7'd16, 9'd26, 7'd36, 8'd46));
    req_queue.push_back(mk_insert(8'd70, 7'd17, 9'd27, 7'd37, 8'd47));
    // table full: zero and a too-small number are not placed, a mid number drops the last
    req_queue.push_back(mk_insert(8'd0, 7'd5, 9'd5, 7'd5, 8'd5));
    req_queue.push_back(mk_insert(8'd60, 7'd18, 9'd28, 7'd38, 8'd48));
    req_queue.push_back(mk_insert(8'd10, 7'd19, 9'd29, 7'd39, 8'd49));
    req_queue.push_back(mk_read(4'd11));
    req_queue.push_back(mk_read(4'd12));
    req_queue.push_back(mk_read(4'd0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      queue_random(RANDOM_PER_PHASE);
      // sender stays quiet until every expected result is back
      while (req_queue.size() != 0 || in_valid || results_due.size() != 0)
        @(negedge clk);
    end

    repeat (4) @(negedge clk);
    if (mismatches == 0 && results_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
hdl/sst_pkg.sv
hdl/sst_cell.sv
hdl/sorted_satellite_table_insert_top.sv
tb/tb_top.sv
